// ----- design/esp_pkg.sv -----
// ----------------------------------------------------------------------------
// esp_pkg: shared types, constants and saturation helpers
// Holds the fixed widths of the encoder speed PID datapath, the register
// indexes and the control bundle of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package esp_pkg;

    localparam int COUNT_W  = 16;
    localparam int TARGET_W = 16;
    localparam int GAIN_W   = 16;
    localparam int FRAC_W   = 8;
    localparam int SPEED_W  = 32;
    localparam int ERR_W    = 32;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int SUM_W    = 40;
    localparam int DRIVE_W  = 32;
    localparam int SPLIT_W  = 24;
    localparam int OPND_W   = SPLIT_W + 1;
    localparam int PROD_W   = OPND_W + GAIN_W + 1;
    localparam int ACC_W    = 58;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 8'd3;

    localparam logic [GAIN_W-1:0] SPEED_GAIN_RST = 16'd154;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd51;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd13;

    localparam logic signed [ACC_W-1:0] SAT32_MAX =
        {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT32_MIN =
        {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0] speed;
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gains_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic hi;
    } mac_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SAT32_MAX) begin
            r = SAT32_MAX;
        end else if (v < SAT32_MIN) begin
            r = SAT32_MIN;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W:0] r;
        if (v > SUM_MAX) begin
            r = SUM_MAX;
        end else if (v < SUM_MIN) begin
            r = SUM_MIN;
        end else begin
            r = v;
        end
        return r[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/esp_cfg.sv -----
// ----------------------------------------------------------------------------
// esp_cfg: gain register file
// Decodes configuration write transactions into the four Q8.8 gain registers.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_cfg
    import esp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [GAIN_W-1:0]    cfg_data,
    output gains_t                    gains
);

    gains_t gains_reg;

    assign cfg_ready = 1'b1;
    assign gains     = gains_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.speed <= SPEED_GAIN_RST;
            gains_reg.prop  <= PROP_GAIN_RST;
            gains_reg.integ <= INTEG_GAIN_RST;
            gains_reg.deriv <= DERIV_GAIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SPEED_GAIN: gains_reg.speed <= cfg_data;
                CFG_PROP_GAIN:  gains_reg.prop  <= cfg_data;
                CFG_INTEG_GAIN: gains_reg.integ <= cfg_data;
                CFG_DERIV_GAIN: gains_reg.deriv <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/esp_mac.sv -----
// ----------------------------------------------------------------------------
// esp_mac: shared multiply-accumulate unit
// Multiplies a signed operand slice by an unsigned gain, registers the
// product, and adds it into a wide accumulator, shifted up by one slice
// width for the upper operand slice.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_mac
    import esp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mac_ctrl_t                ctrl,
    input  wire logic signed [OPND_W-1:0] opnd,
    input  wire logic [GAIN_W-1:0]        gain,
    output logic signed [ACC_W-1:0]       acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pvld_reg;
    logic                     phi_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign addend   = phi_reg ? (prod_ext <<< SPLIT_W) : prod_ext;
    assign acc      = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvld_reg <= 1'b0;
            phi_reg  <= 1'b0;
        end else begin
            pvld_reg <= ctrl.issue;
            phi_reg  <= ctrl.hi;
        end
        prod_reg <= opnd * $signed({1'b0, gain});
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (pvld_reg) begin
            acc_reg <= acc_reg + addend;
        end
    end

endmodule

`default_nettype wire

// ----- design/encoder_speed_pid.sv -----
// Inputs are taken only while the sequencer is idle, so one transaction is finished
// before the next is accepted; the one shared 25x17 multiplier forms the speed
// product and six partial PID products in turn.
// A stalled result holds the sequencer in its final step until it is taken.
// Reset: synchronous active-low aresetn restores default gains, zeroes the
// previous count, error sum and previous error, and empties the output register.
// ----------------------------------------------------------------------------
// encoder_speed_pid: encoder speed measurement and PID speed controller
// Forms the wrapped count change, scales it to a Q24.8 speed and runs a
// saturating positional PID on the speed error with one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_pid
    import esp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // encoder_count [15:0], target_speed [31:16]
    input  wire logic [31:0]          s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // count_delta [15:0], measured_speed [47:16], drive_out [79:48]
    output logic [79:0]               m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [GAIN_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SPD, ST_SPDW, ST_SAT, ST_ERR, ST_SUM, ST_MUL, ST_DRN, ST_OUT
    } state_t;

    state_t                       state_reg;
    logic [2:0]                   cnt_reg;
    logic [COUNT_W-1:0]           prev_count_reg;
    logic signed [TARGET_W-1:0]   target_reg;
    logic signed [COUNT_W-1:0]    delta_reg;
    logic signed [SPEED_W-1:0]    speed_reg;
    logic signed [ERR_W-1:0]      err_reg;
    logic signed [ERR_W-1:0]      prev_err_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [DERIV_W-1:0]    deriv_reg;
    logic                         m_tvalid_reg;
    logic [79:0]                  m_tdata_reg;

    gains_t                       gains;
    mac_ctrl_t                    mac_ctrl;
    logic signed [OPND_W-1:0]     opnd;
    logic [GAIN_W-1:0]            gain;
    logic signed [ACC_W-1:0]      acc;
    logic signed [SUM_W-1:0]      mul_val;
    logic signed [SPEED_W:0]      err_wide;
    logic signed [SUM_W:0]        sum_wide;
    logic                         in_fire;
    logic                         out_load;
    logic signed [DRIVE_W-1:0]    drive_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign err_wide = {{(SPEED_W+1-TARGET_W-FRAC_W){target_reg[TARGET_W-1]}},
                       target_reg, {FRAC_W{1'b0}}}
                    - {speed_reg[SPEED_W-1], speed_reg};
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign drive_next = sat32(acc >>> FRAC_W);

    esp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    always_comb begin
        case (cnt_reg[2:1])
            2'd0:    mul_val = {{(SUM_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            2'd1:    mul_val = sum_reg;
            2'd2:    mul_val = {{(SUM_W-DERIV_W){deriv_reg[DERIV_W-1]}}, deriv_reg};
            default: mul_val = '0;
        endcase
        case (cnt_reg[2:1])
            2'd0:    gain = gains.prop;
            2'd1:    gain = gains.integ;
            2'd2:    gain = gains.deriv;
            default: gain = '0;
        endcase
        mac_ctrl.clear = in_fire || (state_reg == ST_SUM);
        mac_ctrl.issue = (state_reg == ST_SPD) || (state_reg == ST_MUL);
        mac_ctrl.hi    = (state_reg == ST_MUL) && cnt_reg[0];
        if (state_reg == ST_SPD) begin
            opnd = {{(OPND_W-COUNT_W){delta_reg[COUNT_W-1]}}, delta_reg};
            gain = gains.speed;
        end else if (cnt_reg[0]) begin
            opnd = {{(OPND_W-(SUM_W-SPLIT_W)){mul_val[SUM_W-1]}},
                    mul_val[SUM_W-1:SPLIT_W]};
        end else begin
            opnd = {1'b0, mul_val[SPLIT_W-1:0]};
        end
    end

    esp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .opnd    (opnd),
        .gain    (gain),
        .acc     (acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            prev_count_reg <= '0;
            prev_err_reg   <= '0;
            sum_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        delta_reg      <= s_tdata[COUNT_W-1:0] - prev_count_reg;
                        prev_count_reg <= s_tdata[COUNT_W-1:0];
                        target_reg     <= s_tdata[COUNT_W+TARGET_W-1:COUNT_W];
                        state_reg      <= ST_SPD;
                    end
                end
                ST_SPD:  state_reg <= ST_SPDW;
                ST_SPDW: state_reg <= ST_SAT;
                ST_SAT: begin
                    speed_reg <= sat32(acc);
                    state_reg <= ST_ERR;
                end
                ST_ERR: begin
                    err_reg   <= sat32({{(ACC_W-SPEED_W-1){err_wide[SPEED_W]}}, err_wide});
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sum_reg      <= sat_sum(sum_wide);
                    deriv_reg    <= {err_reg[ERR_W-1], err_reg}
                                  - {prev_err_reg[ERR_W-1], prev_err_reg};
                    prev_err_reg <= err_reg;
                    cnt_reg      <= '0;
                    state_reg    <= ST_MUL;
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd5) begin
                        state_reg <= ST_DRN;
                    end
                end
                ST_DRN:  state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_load) begin
                        m_tdata_reg <= {drive_next, speed_reg, delta_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_encoder_speed_pid.sv -----
// ----------------------------------------------------------------------------
// tb_encoder_speed_pid: self-checking bench for the encoder speed PID block
// Streams encoder samples into the block and predicts every result with its own
// fixed-point model of the count wrap, speed scaling and saturating PID. Both
// stream sides stall at random, the result side is once held off long enough to
// back up the input, and the gains are reprogrammed between phases of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import esp_pkg::*;

typedef struct packed {
    logic signed [15:0] target;
    logic [15:0]        count;
} sample_t;

typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] speed;
    logic signed [15:0] delta;
} result_t;

localparam longint W32_MAX = 64'sh0000_0000_7FFF_FFFF;
localparam longint W32_MIN = -W32_MAX - 64'sd1;
localparam longint W64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
localparam longint W64_MIN = -W64_MAX - 64'sd1;
localparam longint SUM_HI  = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
localparam longint SUM_LO  = -SUM_HI - 64'sd1;

class pid_mirror;
    gains_t                  gains;
    logic [15:0]             last_count;
    logic signed [SUM_W-1:0] err_sum;
    logic signed [31:0]      last_err;
    result_t                 queued_results[$];
    int                      mismatches;
    int                      samples;
    int                      outputs;

    function new();
        gains      = '{SPEED_GAIN_RST, PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST};
        last_count = '0;
        err_sum    = '0;
        last_err   = '0;
        mismatches = 0;
        samples    = 0;
        outputs    = 0;
    endfunction

    function longint limit(input logic signed [127:0] v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return longint'(v);
    endfunction

    function void write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        case (idx)
            CFG_SPEED_GAIN: begin
                gains.speed = val;
            end
            CFG_PROP_GAIN: begin
                gains.prop = val;
            end
            CFG_INTEG_GAIN: begin
                gains.integ = val;
            end
            CFG_DERIV_GAIN: begin
                gains.deriv = val;
            end
            default: begin
            end
        endcase
    endfunction

    function void take_sample(input logic [31:0] raw);
        sample_t     s;
        result_t     r;
        logic [15:0] diff;
        longint      delta;
        longint      speed;
        longint      err;
        longint      deriv;
        longint      acc;
        s     = raw;
        diff  = s.count - last_count;
        delta = longint'($signed(diff));
        last_count = s.count;
        speed = limit(delta * longint'(gains.speed), W32_MIN, W32_MAX);
        err   = limit(longint'(s.target) * (64'sd1 <<< FRAC_W) - speed, W32_MIN, W32_MAX);
        err_sum  = SUM_W'(limit(longint'(err_sum) + err, SUM_LO, SUM_HI));
        deriv    = err - longint'(last_err);
        last_err = 32'(err);
        acc = limit(longint'(gains.prop) * err, W64_MIN, W64_MAX);
        acc = limit(acc + limit(longint'(gains.integ) * longint'(err_sum), W64_MIN, W64_MAX),
                    W64_MIN, W64_MAX);
        acc = limit(acc + limit(longint'(gains.deriv) * deriv, W64_MIN, W64_MAX),
                    W64_MIN, W64_MAX);
        r.delta = 16'(delta);
        r.speed = 32'(speed);
        r.drive = 32'(limit(acc >>> FRAC_W, W32_MIN, W32_MAX));
        queued_results.push_back(r);
        samples++;
    endfunction

    function void check_output(input logic [79:0] raw);
        result_t got;
        result_t want;
        got = raw;
        outputs++;
        if (queued_results.size() == 0) begin
            $error("Result transaction with no sample pending: %h", raw);
            mismatches++;
            return;
        end
        want = queued_results.pop_front();
        if (got.delta !== want.delta) begin
            $error("count_delta: expected %0d, actual %0d", want.delta, got.delta);
            mismatches++;
        end
        if (got.speed !== want.speed) begin
            $error("measured_speed: expected %0d, actual %0d", want.speed, got.speed);
            mismatches++;
        end
        if (got.drive !== want.drive) begin
            $error("drive_out: expected %0d, actual %0d", want.drive, got.drive);
            mismatches++;
        end
    endfunction
endclass

module tb_encoder_speed_pid;

    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [79:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    pid_mirror   sb = new();
    logic [15:0] enc_pos;
    bit          steady;
    bit          hold_req;
    int          held_cycles;
    int          settings;
    int unsigned cycles = 0;

    encoder_speed_pid u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_output(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.take_sample(s_tdata);
            end
        end
    end

    initial begin
        m_tready    = 1'b0;
        held_cycles = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    held_cycles++;
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    task automatic send_sample(input logic [15:0] cnt, input logic [15:0] tgt);
        if (!steady && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tgt, cnt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_gain(idx, val);
        @(negedge aclk);
    endtask

    task automatic set_gains(input gains_t g, input logic [CFG_IDX_W-1:0] unused_idx);
        write_reg(CFG_SPEED_GAIN, g.speed);
        write_reg(CFG_PROP_GAIN, g.prop);
        write_reg(CFG_INTEG_GAIN, g.integ);
        write_reg(CFG_DERIV_GAIN, g.deriv);
        write_reg(unused_idx, 16'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.queued_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_target();
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom_range(0, 6000) - 3000);
        end
        return 16'($urandom);
    endfunction

    task automatic run_random(input int n, input int hold_at);
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) begin
                hold_req = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: begin
                    enc_pos = enc_pos + 16'h8000;
                end
                1: begin
                    enc_pos = 16'($urandom);
                end
                2: begin
                end
                3, 4: begin
                    enc_pos = enc_pos - 16'($urandom_range(0, 2000));
                end
                default: begin
                    enc_pos = enc_pos + 16'($urandom_range(0, 2000));
                end
            endcase
            send_sample(enc_pos, pick_target());
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        hold_req  = 1'b0;
        settings  = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default gains: zero change, wraps at both ends and the half-range jump.
        send_sample(16'd0, 16'd0);
        send_sample(16'd100, 16'd60);
        send_sample(16'hFFFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'd0, 16'hFFFF);
        send_sample(16'h7FFF, 16'd1);
        send_sample(16'h7FFF, 16'd0);
        drain();

        // Full-scale gains drive the error and the output into both limits.
        set_gains('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 8'hFF);
        send_sample(16'd0, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'd0, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'hFFFE, 16'h8000);
        drain();

        set_gains('{16'd0, 16'd0, 16'd0, 16'd0}, 8'($urandom_range(4, 255)));
        send_sample(16'd1, 16'd5);
        send_sample(16'd40000, 16'hFFF9);
        drain();

        set_gains('{SPEED_GAIN_RST, PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST},
                  8'($urandom_range(4, 255)));
        enc_pos = 16'd40000;
        run_random(70, 30);
        drain();

        // Sustained underspeed error with no stalls winds the integrator into its limit.
        set_gains('{16'hFFFF, 16'($urandom), 16'hFFFF, 16'($urandom)},
                  8'($urandom_range(4, 255)));
        steady = 1'b1;
        for (int i = 0; i < 290; i++) begin
            if ($urandom_range(0, 99) < 95) begin
                enc_pos = enc_pos + 16'h8000;
                send_sample(enc_pos, 16'($urandom_range(16'h0080, 16'h7FFF)));
            end else begin
                enc_pos = 16'($urandom);
                send_sample(enc_pos, pick_target());
            end
        end
        drain();
        steady = 1'b0;

        set_gains('{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                  8'($urandom_range(4, 255)));
        run_random(45, -1);
        drain();

        set_gains('{16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                    16'($urandom_range(0, 600)), 16'($urandom_range(0, 600))},
                  8'($urandom_range(4, 255)));
        run_random(45, -1);
        drain();
        repeat (30) @(negedge aclk);

        $display("Sent %0d samples and checked %0d results over %0d gain settings.",
                 sb.samples, sb.outputs, settings);
        $display("Result side held off for %0d cycles; integrator wind-up phase included.",
                 held_cycles);
        if (sb.mismatches == 0 && sb.queued_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
